// ----- rtl/stp_pkg.sv -----
`default_nettype none
package stp_pkg;

    localparam int ANGLE_FRACTION_BITS = 13;
    localparam int CORDIC_STAGES = 16;
    localparam int SQRT_STEPS = 15;
    localparam int PIPE_STAGES = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
    localparam int IDX_W = $clog2(PIPE_STAGES);
    localparam int CW = 27;
    localparam int ZW = 40;
    localparam int SQW = 24;
    localparam int RW = 31;
    localparam int AXIS_SPAN = 128;

    localparam logic signed [ZW-1:0] PI_Q32 = 40'sd13493037705;
    localparam logic signed [ZW-1:0] HALF_PI_Q32 = 40'sd6746518852;
    localparam logic signed [ZW-1:0] QUARTER_PI_Q32 = 40'sd3373259426;
    localparam logic [14:0] DRIVE_MAX = 15'd25600;
    localparam logic [15:0] MAG_LIMIT = 16'd10000;

    typedef logic signed [ZW-1:0] atan_tab_t [PIPE_STAGES];
    typedef logic [SQW-1:0] sq_tab_t [AXIS_SPAN+1];

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [ZW-1:0] z;
        logic [RW-1:0] sq_val;
        logic [RW-1:0] sq_res;
        logic x_zero;
        logic y_zero;
        logic y_pos;
        logic x_neg;
        logic mag_big;
    } stp_data_t;

    // restoring long division, used only while building tables
    function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | (64'd1 << b);
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in Q32, Taylor series in Q62 rounded half up
    function automatic atan_tab_t build_atan_tab();
        atan_tab_t tab;
        longint sum;
        longint term;
        int e;
        for (int i = 0; i < PIPE_STAGES; i++)
        begin
            sum = 0;
            if (i >= CORDIC_STAGES)
            begin
                tab[i] = '0;
            end
            else if (i == 0)
            begin
                tab[i] = QUARTER_PI_Q32;
            end
            else
            begin
                for (int k = 0; k < 32; k++)
                begin
                    e = i * (2 * k + 1);
                    if (e <= 62)
                    begin
                        term = longint'(div_u64(64'd1 << (62 - e), longint'(2 * k + 1)));
                        sum = ((k & 1) == 1) ? sum - term : sum + term;
                    end
                end
                tab[i] = ZW'((sum + (longint'(1) << 29)) >>> 30);
            end
        end
        return tab;
    endfunction

    // isqrt((20000 - v*v) << 32)
    function automatic sq_tab_t build_sq_tab();
        sq_tab_t tab;
        longint unsigned val;
        longint unsigned res;
        longint unsigned bitv;
        for (int v = 0; v <= AXIS_SPAN; v++)
        begin
            val = longint'(20000 - v * v) << 32;
            res = 0;
            for (int j = 0; j < 32; j++)
            begin
                bitv = 64'd1 << (62 - 2 * j);
                if (val >= res + bitv)
                begin
                    val = val - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                begin
                    res = res >> 1;
                end
            end
            tab[v] = SQW'(res);
        end
        return tab;
    endfunction

    localparam atan_tab_t ATAN_TAB = build_atan_tab();
    localparam sq_tab_t SQ_TAB = build_sq_tab();

endpackage
`default_nettype wire

// ----- rtl/stick_to_polar.sv -----
`default_nettype none
// Joystick sample (stick_x, stick_y) to heading (Q2.13 radian, -pi..pi) and
// drive_level (Q.8 magnitude, held at 100). Fully pipelined: one transaction
// per cycle unless out_stall holds it. Stages: input prep stage, one stage per
// CORDIC rotation / square-root digit, output register. Each stage holds only
// while it is full and its successor is blocked, so bubbles are squeezed.
module stick_to_polar (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [7:0]  stick_x,
    input  wire logic signed [7:0]  stick_y,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      heading,
    output logic [14:0]             drive_level
);

    localparam int N = stp_pkg::PIPE_STAGES;

    logic [N:0] valid_pipe;
    logic [N+1:0] ready;
    stp_pkg::stp_data_t data_pipe [N+1];

    assign ready[N+1] = !out_valid || !out_stall;
    assign in_stall = !ready[0];

    stp_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (ready[0]),
        .in_valid  (in_valid),
        .x         (stick_x),
        .y         (stick_y),
        .valid_reg (valid_pipe[0]),
        .data_reg  (data_pipe[0])
    );

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        assign ready[k] = !valid_pipe[k] || ready[k+1];
        stp_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (ready[k+1]),
            .idx       (stp_pkg::IDX_W'(k)),
            .in_valid  (valid_pipe[k]),
            .in_data   (data_pipe[k]),
            .valid_reg (valid_pipe[k+1]),
            .data_reg  (data_pipe[k+1])
        );
    end

    assign ready[N] = !valid_pipe[N] || ready[N+1];

    stp_post u_post (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (ready[N+1]),
        .in_valid        (valid_pipe[N]),
        .in_data         (data_pipe[N]),
        .valid_reg       (out_valid),
        .heading_reg     (heading),
        .drive_level_reg (drive_level)
    );

endmodule
`default_nettype wire

// ----- rtl/stp_prep.sv -----
`default_nettype none
module stp_prep (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic signed [7:0]       x,
    input  wire logic signed [7:0]       y,
    output logic                         valid_reg,
    output stp_pkg::stp_data_t           data_reg
);

    stp_pkg::stp_data_t data_next;
    logic [7:0] ax;
    logic [7:0] ay;
    logic x_edge;
    logic y_edge;
    logic [15:0] sum_sq;

    always_comb
    begin
        ax = x[7] ? 8'(-x) : 8'(x);
        ay = y[7] ? 8'(-y) : 8'(y);
        x_edge = (x == 8'sd100) || (x == -8'sd100);
        y_edge = (y == 8'sd100) || (y == -8'sd100);
        sum_sq = 16'(ax * ax) + 16'(ay * ay);

        data_next = '0;
        if (x_edge)
            data_next.cx = $signed(stp_pkg::CW'(stp_pkg::SQ_TAB[ay]));
        else
            data_next.cx = $signed({3'b000, ax, 16'b0});
        if (y_edge)
            data_next.cy = y[7] ? -$signed(stp_pkg::CW'(stp_pkg::SQ_TAB[ax]))
                                : $signed(stp_pkg::CW'(stp_pkg::SQ_TAB[ax]));
        else
            data_next.cy = $signed({{3{y[7]}}, y, 16'b0});
        data_next.z = '0;
        data_next.mag_big = sum_sq > stp_pkg::MAG_LIMIT;
        data_next.sq_val = data_next.mag_big ? '0 : {sum_sq[14:0], 16'b0};
        data_next.sq_res = '0;
        data_next.x_zero = (x == 8'sd0);
        data_next.y_zero = (y == 8'sd0);
        data_next.y_pos = (y > 8'sd0);
        data_next.x_neg = x[7];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ----- rtl/stp_stage.sv -----
`default_nettype none
module stp_stage (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic [stp_pkg::IDX_W-1:0]   idx,
    input  wire logic                        in_valid,
    input  wire stp_pkg::stp_data_t          in_data,
    output logic                             valid_reg,
    output stp_pkg::stp_data_t               data_reg
);

    stp_pkg::stp_data_t data_next;
    logic signed [stp_pkg::CW-1:0] dx;
    logic signed [stp_pkg::CW-1:0] dy;
    logic [stp_pkg::RW-1:0] sbit;
    logic [stp_pkg::RW-1:0] trial;

    always_comb
    begin
        data_next = in_data;
        dx = in_data.cy >>> idx;
        dy = in_data.cx >>> idx;
        sbit = stp_pkg::RW'(1) << (2 * (stp_pkg::SQRT_STEPS - 1 - int'(idx)));
        trial = in_data.sq_res + sbit;
        if (int'(idx) < stp_pkg::CORDIC_STAGES)
        begin
            if (!in_data.cy[stp_pkg::CW-1])
            begin
                data_next.cx = in_data.cx + dx;
                data_next.cy = in_data.cy - dy;
                data_next.z = in_data.z + stp_pkg::ATAN_TAB[idx];
            end
            else
            begin
                data_next.cx = in_data.cx - dx;
                data_next.cy = in_data.cy + dy;
                data_next.z = in_data.z - stp_pkg::ATAN_TAB[idx];
            end
        end
        if (int'(idx) < stp_pkg::SQRT_STEPS)
        begin
            if (in_data.sq_val >= trial)
            begin
                data_next.sq_val = in_data.sq_val - trial;
                data_next.sq_res = (in_data.sq_res >> 1) + sbit;
            end
            else
            begin
                data_next.sq_res = in_data.sq_res >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ----- rtl/stp_post.sv -----
`default_nettype none
module stp_post (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire stp_pkg::stp_data_t      in_data,
    output logic                         valid_reg,
    output logic signed [15:0]           heading_reg,
    output logic [14:0]                  drive_level_reg
);

    localparam int SH = 32 - stp_pkg::ANGLE_FRACTION_BITS;

    logic signed [stp_pkg::ZW-1:0] a;
    logic signed [stp_pkg::ZW-1:0] h;
    logic signed [stp_pkg::ZW-1:0] hr;
    logic signed [15:0] heading_next;
    logic [14:0] drive_level_next;

    always_comb
    begin
        a = in_data.y_zero ? '0 : in_data.z;
        if (in_data.x_zero && in_data.y_zero)
            h = '0;
        else if (in_data.x_zero)
            h = in_data.y_pos ? stp_pkg::HALF_PI_Q32 : -stp_pkg::HALF_PI_Q32;
        else if (!in_data.x_neg)
            h = a;
        else if (in_data.y_pos)
            h = stp_pkg::PI_Q32 - a;
        else
            h = -stp_pkg::PI_Q32 - a;
        hr = (h + (stp_pkg::ZW'(1) <<< (SH - 1))) >>> SH;
        heading_next = hr[15:0];
        drive_level_next = in_data.mag_big ? stp_pkg::DRIVE_MAX : in_data.sq_res[14:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            heading_reg <= heading_next;
            drive_level_reg <= drive_level_next;
        end
    end

endmodule
`default_nettype wire
